### design/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg: shared constants and types of the 3x3 sharpen stream
// Frame limits, derived widths, register indexes and the beat records that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package shp_pkg;

   // frame limits
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_HEIGHT   = 4096;
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

   // derived widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int PIX_W  = 8;
   localparam int PIX_MAX = (1 << PIX_W) - 1;

   // kernel gain on the center sample
   localparam int CENTRE_GAIN = 5;

   // configuration registers
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CHAN_REG_W   = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam int MIN_WIDTH     = 3;
   localparam int MIN_HEIGHT    = 3;
   localparam int MIN_CHANNELS  = 1;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int CHAN_RESET    = 3;

   // one accepted sample in flight through the first stage
   typedef struct packed {
      logic [PIX_W-1:0]  sample;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [CH_W-1:0]   channel;
      logic [ADDR_W-1:0] addr;
      logic              has_main;    // result for (r-1, c-1)
      logic              has_right;   // right border zero
      logic              has_bottom;  // bottom row zero
      logic              at_end;      // last column, last channel
      logic              calc_ok;     // kernel value is not forced to zero
   } beat_info_type;

   // results of one sample, handed to the output sequencer
   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [CH_W-1:0]  channel;
      logic             has_main;
      logic             has_right;
      logic             has_bottom;
      logic             at_end;
   } result_item_type;

endpackage

### design/sharpen_3x3_stream.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_stream: streaming 3x3 Laplacian sharpen, interleaved channels
// The beat is registered in stage one, then its results in the output register.
// Throughput: one sample per cycle while the result channel does not stall; a sample
//   with several results (last row, row end) holds the input until they leave, one a cycle.
// The result for (r-1, c-1) leaves with the sample at (r, c).
// Reset: counters to frame start, 640 x 480 x 3, pipeline empty; line
//   memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sharpen_3x3_stream (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [shp_pkg::PIX_W-1:0]          req_pixel_sample,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [shp_pkg::PIX_W-1:0]          rsp_sharpened_value,
   output logic [shp_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [shp_pkg::COL_W-1:0]          rsp_out_column,
   output logic [shp_pkg::CH_W-1:0]           rsp_out_channel,
   output logic                               rsp_frame_last,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [shp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [shp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   // configuration, kept as last index of each dimension
   logic [shp_pkg::COL_W-1:0]        width_last_ff,  width_last_in;
   logic [shp_pkg::ROW_W-1:0]        height_last_ff, height_last_in;
   logic [shp_pkg::CH_W-1:0]         chan_last_ff,   chan_last_in;
   logic                             cfg_hit;
   logic [shp_pkg::WIDTH_REG_W-1:0]  width_sat;
   logic [shp_pkg::HEIGHT_REG_W-1:0] height_sat;
   logic [shp_pkg::CHAN_REG_W-1:0]   chan_sat;

   // raster position
   logic [shp_pkg::ROW_W-1:0]  row_ff,  row_in;
   logic [shp_pkg::COL_W-1:0]  col_ff,  col_in;
   logic [shp_pkg::CH_W-1:0]   chan_ff, chan_in;
   logic [shp_pkg::ADDR_W-1:0] addr_ff, addr_in;

   // first stage
   logic                     s1_valid_ff, s1_valid_in;
   shp_pkg::beat_info_type   s1_info_ff,  s1_info_in;
   logic                     accept;
   logic                     s1_adv;
   logic                     seq_ready;

   logic [shp_pkg::PIX_W-1:0] mid_q;
   logic [shp_pkg::PIX_W-1:0] up_q;
   logic [shp_pkg::PIX_W-1:0] kernel_value;
   shp_pkg::result_item_type  result_item;

   // handshake
   assign s1_adv    = s1_valid_ff && seq_ready;
   assign req_stall = s1_valid_ff && !seq_ready;
   assign accept    = req_valid && !req_stall;

   // saturate register writes into the supported range
   always_comb begin
      width_sat  = csr_wr_data[shp_pkg::WIDTH_REG_W-1:0];
      height_sat = csr_wr_data[shp_pkg::HEIGHT_REG_W-1:0];
      chan_sat   = csr_wr_data[shp_pkg::CHAN_REG_W-1:0];
      if (width_sat < shp_pkg::WIDTH_REG_W'(shp_pkg::MIN_WIDTH)) begin
         width_sat = shp_pkg::WIDTH_REG_W'(shp_pkg::MIN_WIDTH);
      end else if (width_sat > shp_pkg::WIDTH_REG_W'(shp_pkg::MAX_WIDTH)) begin
         width_sat = shp_pkg::WIDTH_REG_W'(shp_pkg::MAX_WIDTH);
      end
      if (height_sat < shp_pkg::HEIGHT_REG_W'(shp_pkg::MIN_HEIGHT)) begin
         height_sat = shp_pkg::HEIGHT_REG_W'(shp_pkg::MIN_HEIGHT);
      end else if (height_sat > shp_pkg::HEIGHT_REG_W'(shp_pkg::MAX_HEIGHT)) begin
         height_sat = shp_pkg::HEIGHT_REG_W'(shp_pkg::MAX_HEIGHT);
      end
      if (chan_sat < shp_pkg::CHAN_REG_W'(shp_pkg::MIN_CHANNELS)) begin
         chan_sat = shp_pkg::CHAN_REG_W'(shp_pkg::MIN_CHANNELS);
      end else if (chan_sat > shp_pkg::CHAN_REG_W'(shp_pkg::MAX_CHANNELS)) begin
         chan_sat = shp_pkg::CHAN_REG_W'(shp_pkg::MAX_CHANNELS);
      end
   end

   // register decode
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      chan_last_in   = chan_last_ff;
      cfg_hit        = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            shp_pkg::REG_IMAGE_WIDTH: begin
               width_last_in = shp_pkg::COL_W'(width_sat - shp_pkg::WIDTH_REG_W'(1));
               cfg_hit       = 1'b1;
            end
            shp_pkg::REG_IMAGE_HEIGHT: begin
               height_last_in = shp_pkg::ROW_W'(height_sat - shp_pkg::HEIGHT_REG_W'(1));
               cfg_hit        = 1'b1;
            end
            shp_pkg::REG_CHANNEL_COUNT: begin
               chan_last_in = shp_pkg::CH_W'(chan_sat - shp_pkg::CHAN_REG_W'(1));
               cfg_hit      = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // raster counters and line address
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      chan_in = chan_ff;
      addr_in = addr_ff;
      if (cfg_hit) begin
         row_in  = '0;
         col_in  = '0;
         chan_in = '0;
         addr_in = '0;
      end else if (accept) begin
         addr_in = addr_ff + shp_pkg::ADDR_W'(1);
         if (chan_ff == chan_last_ff) begin
            chan_in = '0;
            if (col_ff == width_last_ff) begin
               col_in  = '0;
               addr_in = '0;
               row_in  = (row_ff == height_last_ff) ? '0 : row_ff + shp_pkg::ROW_W'(1);
            end else begin
               col_in = col_ff + shp_pkg::COL_W'(1);
            end
         end else begin
            chan_in = chan_ff + shp_pkg::CH_W'(1);
         end
      end
   end

   // classify the incoming beat
   always_comb begin
      s1_info_in.sample     = req_pixel_sample;
      s1_info_in.row        = row_ff;
      s1_info_in.column     = col_ff;
      s1_info_in.channel    = chan_ff;
      s1_info_in.addr       = addr_ff;
      s1_info_in.has_main   = (row_ff != '0) && (col_ff != '0);
      s1_info_in.has_right  = (row_ff != '0) && (col_ff == width_last_ff);
      s1_info_in.has_bottom = (row_ff == height_last_ff);
      s1_info_in.at_end     = (col_ff == width_last_ff) && (chan_ff == chan_last_ff);
      s1_info_in.calc_ok    = (row_ff > shp_pkg::ROW_W'(1)) && (col_ff > shp_pkg::COL_W'(1));
      s1_valid_in           = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= shp_pkg::COL_W'(shp_pkg::WIDTH_RESET - 1);
         height_last_ff <= shp_pkg::ROW_W'(shp_pkg::HEIGHT_RESET - 1);
         chan_last_ff   <= shp_pkg::CH_W'(shp_pkg::CHAN_RESET - 1);
         row_ff         <= '0;
         col_ff         <= '0;
         chan_ff        <= '0;
         addr_ff        <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         chan_last_ff   <= chan_last_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         chan_ff        <= chan_in;
         addr_ff        <= addr_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= s1_info_in;
      end
   end

   // line memories: read on accept, write back as the beat leaves stage one
   shp_line_store u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (addr_ff),
      .wr_en     (s1_adv),
      .wr_addr   (s1_info_ff.addr),
      .wr_sample (s1_info_ff.sample),
      .mid_q     (mid_q),
      .up_q      (up_q)
   );

   shp_kernel u_kernel (
      .clock   (clock),
      .advance (s1_adv),
      .info    (s1_info_ff),
      .mid_q   (mid_q),
      .up_q    (up_q),
      .value   (kernel_value)
   );

   always_comb begin
      result_item.value      = kernel_value;
      result_item.row        = s1_info_ff.row;
      result_item.column     = s1_info_ff.column;
      result_item.channel    = s1_info_ff.channel;
      result_item.has_main   = s1_info_ff.has_main;
      result_item.has_right  = s1_info_ff.has_right;
      result_item.has_bottom = s1_info_ff.has_bottom;
      result_item.at_end     = s1_info_ff.at_end;
   end

   shp_result_seq u_result_seq (
      .clock               (clock),
      .reset               (reset),
      .load                (s1_adv),
      .item                (result_item),
      .ready               (seq_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sharpened_value (rsp_sharpened_value),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_column      (rsp_out_column),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_frame_last      (rsp_frame_last)
   );

   // input only waits on an occupied first stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with stage one empty");

   // first row and first column are border samples
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_row == '0 || rsp_out_column == '0))
      |-> rsp_sharpened_value == '0)
      else $error("nonzero value on the top or left border");

   // frame end is a bottom row beat
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_sharpened_value == '0)
      else $error("frame end beat carries a kernel value");

endmodule

### design/shp_line_store.sv
// ----------------------------------------------------------------------------
// shp_line_store: the two line memories
// Middle holds the row above, upper the row two above. A read fetches both
// at one address; the write puts the new sample into middle and moves the
// fetched middle value into upper at the same address.
// ----------------------------------------------------------------------------
module shp_line_store (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [shp_pkg::ADDR_W-1:0] rd_addr,
   input  logic                       wr_en,
   input  logic [shp_pkg::ADDR_W-1:0] wr_addr,
   input  logic [shp_pkg::PIX_W-1:0]  wr_sample,
   output logic [shp_pkg::PIX_W-1:0]  mid_q,
   output logic [shp_pkg::PIX_W-1:0]  up_q
);

   logic [shp_pkg::PIX_W-1:0] middle_store_ff [shp_pkg::STORE_DEPTH];
   logic [shp_pkg::PIX_W-1:0] upper_store_ff  [shp_pkg::STORE_DEPTH];
   logic [shp_pkg::PIX_W-1:0] mid_rd_ff;
   logic [shp_pkg::PIX_W-1:0] up_rd_ff;

   // read holds its data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_rd_ff <= middle_store_ff[rd_addr];
         up_rd_ff  <= upper_store_ff[rd_addr];
      end
   end

   // write back: new row into middle, old middle down into upper
   always_ff @(posedge clock) begin
      if (wr_en) begin
         middle_store_ff[wr_addr] <= wr_sample;
         upper_store_ff[wr_addr]  <= mid_rd_ff;
      end
   end

   assign mid_q = mid_rd_ff;
   assign up_q  = up_rd_ff;

endmodule

### design/shp_kernel.sv
// ----------------------------------------------------------------------------
// shp_kernel: per-channel window and sharpen arithmetic
// Keeps, per channel, the two previous middle-row samples, the previous
// upper-row sample and the previous current-row sample, and forms
// 5*center - up - down - left - right saturated to the pixel range.
// ----------------------------------------------------------------------------
module shp_kernel (
   input  logic                         clock,
   input  logic                         advance,
   input  shp_pkg::beat_info_type       info,
   input  logic [shp_pkg::PIX_W-1:0]    mid_q,
   input  logic [shp_pkg::PIX_W-1:0]    up_q,
   output logic [shp_pkg::PIX_W-1:0]    value
);

   localparam int SUM_W = shp_pkg::PIX_W + 4;

   logic [shp_pkg::PIX_W-1:0] mid1_ff [shp_pkg::MAX_CHANNELS];
   logic [shp_pkg::PIX_W-1:0] mid2_ff [shp_pkg::MAX_CHANNELS];
   logic [shp_pkg::PIX_W-1:0] up1_ff  [shp_pkg::MAX_CHANNELS];
   logic [shp_pkg::PIX_W-1:0] prev_ff [shp_pkg::MAX_CHANNELS];

   logic [SUM_W-1:0] pos_sum;
   logic [SUM_W-1:0] neg_sum;
   logic [SUM_W-1:0] diff;

   // shift the window of this channel by one column
   always_ff @(posedge clock) begin
      if (advance) begin
         prev_ff[info.channel] <= info.sample;
         mid2_ff[info.channel] <= mid1_ff[info.channel];
         mid1_ff[info.channel] <= mid_q;
         up1_ff[info.channel]  <= up_q;
      end
   end

   // center gain against the four neighbors, then saturate
   always_comb begin
      pos_sum = SUM_W'(mid1_ff[info.channel]) * SUM_W'(shp_pkg::CENTRE_GAIN);
      neg_sum = SUM_W'(up1_ff[info.channel]) + SUM_W'(mid2_ff[info.channel])
              + SUM_W'(mid_q) + SUM_W'(prev_ff[info.channel]);
      diff    = pos_sum - neg_sum;
      if (!info.calc_ok || neg_sum > pos_sum) begin
         value = '0;
      end else if (diff > SUM_W'(shp_pkg::PIX_MAX)) begin
         value = shp_pkg::PIX_W'(shp_pkg::PIX_MAX);
      end else begin
         value = diff[shp_pkg::PIX_W-1:0];
      end
   end

endmodule

### design/shp_result_seq.sv
// ----------------------------------------------------------------------------
// shp_result_seq: output register and result sequencer
// Holds the results of one sample and sends them one beat at a time:
// kernel value, then right border zero, then bottom row zero.
// ----------------------------------------------------------------------------
module shp_result_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  shp_pkg::result_item_type      item,
   output logic                          ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [shp_pkg::PIX_W-1:0]     rsp_sharpened_value,
   output logic [shp_pkg::ROW_W-1:0]     rsp_out_row,
   output logic [shp_pkg::COL_W-1:0]     rsp_out_column,
   output logic [shp_pkg::CH_W-1:0]      rsp_out_channel,
   output logic                          rsp_frame_last
);

   localparam int MASK_MAIN   = 0;
   localparam int MASK_RIGHT  = 1;
   localparam int MASK_BOTTOM = 2;

   shp_pkg::result_item_type item_ff;
   logic [2:0]               mask_ff;
   logic [2:0]               mask_in;
   logic                     beat_done;

   assign rsp_valid = |mask_ff;
   assign beat_done = rsp_valid && !rsp_stall;
   assign ready     = !rsp_valid || (beat_done && $onehot(mask_ff));

   // pending results: load a new set or drop the one just sent
   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = {item.has_bottom, item.has_right, item.has_main};
      end else if (beat_done) begin
         mask_in = mask_ff & (mask_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   // fields of the beat at the head
   always_comb begin
      rsp_out_channel = item_ff.channel;
      if (mask_ff[MASK_MAIN]) begin
         rsp_sharpened_value = item_ff.value;
         rsp_out_row         = item_ff.row - shp_pkg::ROW_W'(1);
         rsp_out_column      = item_ff.column - shp_pkg::COL_W'(1);
         rsp_frame_last      = 1'b0;
      end else if (mask_ff[MASK_RIGHT]) begin
         rsp_sharpened_value = '0;
         rsp_out_row         = item_ff.row - shp_pkg::ROW_W'(1);
         rsp_out_column      = item_ff.column;
         rsp_frame_last      = 1'b0;
      end else begin
         rsp_sharpened_value = '0;
         rsp_out_row         = item_ff.row;
         rsp_out_column      = item_ff.column;
         rsp_frame_last      = mask_ff[MASK_BOTTOM] && item_ff.at_end;
      end
   end

   // a sample with results left keeps the channel busy
   a_more_beats: assert property (@(posedge clock) disable iff (reset)
      (beat_done && !$onehot(mask_ff)) |=> rsp_valid)
      else $error("result dropped between beats of one sample");

endmodule
